// ===== design/swsr_pkg.sv =====
`timescale 1ns / 1ps

package swsr_pkg;

  // sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_START_LOW  = 4'd1,
    PH_START_HIGH = 4'd2,
    PH_RESP_WAIT  = 4'd3,
    PH_RESP_GAP   = 4'd4,
    PH_RESP_FALL  = 4'd5,
    PH_BIT_HIGH   = 4'd6,
    PH_BIT_DELAY  = 4'd7,
    PH_BIT_FALL   = 4'd8
  } phase_t;

  // line drive codes
  localparam logic [1:0] DRIVE_RELEASE = 2'd0;
  localparam logic [1:0] DRIVE_LOW     = 2'd1;
  localparam logic [1:0] DRIVE_HIGH    = 2'd2;

  // response status codes
  localparam logic [1:0] RESP_NONE = 2'd0;
  localparam logic [1:0] RESP_OK   = 2'd1;
  localparam logic [1:0] RESP_FAIL = 2'd2;

  // request kinds
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  // register indexes
  localparam logic [2:0] REG_START_LOW  = 3'd0;
  localparam logic [2:0] REG_START_HIGH = 3'd1;
  localparam logic [2:0] REG_RESP_WAIT  = 3'd2;
  localparam logic [2:0] REG_RESP_GAP   = 3'd3;
  localparam logic [2:0] REG_BIT_SAMPLE = 3'd4;
  localparam logic [2:0] REG_BYTES      = 3'd5;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

// ===== design/swsr_sense_if.sv =====
`timescale 1ns / 1ps

interface swsr_sense_if;
  logic valid;
  logic ready;
  logic func;
  logic pin_level;

  modport source (output valid, output func, output pin_level, input ready);
  modport sink (input valid, input func, input pin_level, output ready);
endinterface

// ===== design/swsr_result_if.sv =====
`timescale 1ns / 1ps

interface swsr_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] line_drive;
  logic       busy_res;
  logic [1:0] response_status;
  logic       byte_valid;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (
    output valid, output line_drive, output busy_res, output response_status,
    output byte_valid, output data_byte, output last_byte, input ready
  );
  modport sink (
    input valid, input line_drive, input busy_res, input response_status,
    input byte_valid, input data_byte, input last_byte, output ready
  );
endinterface

// ===== design/single_wire_sensor_reader_top.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake      payload
// sense     in   valid/ready    func, pin_level
// result    out  valid/ready    line_drive, busy_res, response_status,
//                               byte_valid, data_byte, last_byte
// apb       in   psel/penable   paddr, pwdata, prdata (pready tied high)
//
// every request yields exactly one result, passed from the input register
// through the sequencer step into the result register;
// one request per cycle is sustained while results are taken, the sequencer
// state loop closes combinationally through the phase timer add and compare
// rst is synchronous: phase idle, counters cleared, registers to defaults
// a stalled result holds in the result register while the input register
// keeps one more request; sense.ready drops only when both are full
module single_wire_sensor_reader_top (
  input  logic        clk,
  input  logic        rst,
  swsr_sense_if.sink   sense,
  swsr_result_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import swsr_pkg::*;

  // configuration registers
  logic [15:0] start_low_ticks;
  logic [7:0]  start_high_ticks;
  logic [7:0]  response_wait_ticks;
  logic [7:0]  response_gap_ticks;
  logic [7:0]  bit_sample_ticks;
  logic [3:0]  bytes_to_read;

  // input register
  logic in_valid;
  logic in_func;
  logic in_pin;

  // sequencer state
  phase_t      phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [3:0]  byte_index, byte_index_next;
  logic [7:0]  shift_byte, shift_byte_next;

  // events of this step, consumed by the output logic
  logic       ev_ok, ev_fail, ev_byte, ev_last;
  logic [7:0] ev_data;

  // result fields before the result register
  logic [1:0] drive_d;
  logic       busy_d;
  logic [1:0] status_d;
  logic       bvalid_d;
  logic [7:0] data_d;
  logic       last_d;

  logic advance;
  logic step;

  // phase timer
  logic [15:0] timer_len;
  logic [15:0] tick_inc;
  logic        timer_hit;

  // byte completion
  logic       do_finish;
  logic [3:0] fin_bits;
  logic [7:0] fin_byte;
  logic [4:0] byte_count_inc;

  assign pready = 1'b1;

  // ---------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      start_low_ticks     <= 16'd500;
      start_high_ticks    <= 8'd30;
      response_wait_ticks <= 8'd40;
      response_gap_ticks  <= 8'd80;
      bit_sample_ticks    <= 8'd40;
      bytes_to_read       <= 4'd5;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_START_LOW:  start_low_ticks     <= pwdata[15:0];
        REG_START_HIGH: start_high_ticks    <= pwdata[7:0];
        REG_RESP_WAIT:  response_wait_ticks <= pwdata[7:0];
        REG_RESP_GAP:   response_gap_ticks  <= pwdata[7:0];
        REG_BIT_SAMPLE: bit_sample_ticks    <= pwdata[7:0];
        REG_BYTES:      bytes_to_read       <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_START_LOW:  prdata = {16'd0, start_low_ticks};
      REG_START_HIGH: prdata = {24'd0, start_high_ticks};
      REG_RESP_WAIT:  prdata = {24'd0, response_wait_ticks};
      REG_RESP_GAP:   prdata = {24'd0, response_gap_ticks};
      REG_BIT_SAMPLE: prdata = {24'd0, bit_sample_ticks};
      REG_BYTES:      prdata = {28'd0, bytes_to_read};
      default:        prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // handshake: result register frees up when empty or being taken
  // ---------------------------------------------------------------------
  assign advance     = !result.valid || result.ready;
  assign step        = in_valid && advance;
  assign sense.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sense.valid && sense.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sense.valid && sense.ready) begin
      in_func <= sense.func;
      in_pin  <= sense.pin_level;
    end
  end

  // ---------------------------------------------------------------------
  // phase timer: length picked by phase, zero length acts as one tick
  // ---------------------------------------------------------------------
  always_comb begin
    case (phase)
      PH_START_LOW:  timer_len = start_low_ticks;
      PH_START_HIGH: timer_len = {8'd0, start_high_ticks};
      PH_RESP_WAIT:  timer_len = {8'd0, response_wait_ticks};
      PH_RESP_GAP:   timer_len = {8'd0, response_gap_ticks};
      PH_BIT_DELAY:  timer_len = {8'd0, bit_sample_ticks};
      default:       timer_len = 16'd0;
    endcase
  end

  assign tick_inc       = tick_count + 16'd1;
  assign timer_hit      = (tick_inc >= timer_len);
  assign byte_count_inc = {1'b0, byte_index} + 5'd1;

  // ---------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------
  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    byte_index_next = byte_index;
    shift_byte_next = shift_byte;
    ev_ok           = 1'b0;
    ev_fail         = 1'b0;
    ev_byte         = 1'b0;
    ev_last         = 1'b0;
    ev_data         = 8'd0;
    do_finish       = 1'b0;
    fin_bits        = bit_index;
    fin_byte        = shift_byte;

    if (in_func == FUNC_START) begin
      // start abandons whatever was going on
      phase_next      = PH_START_LOW;
      tick_count_next = 16'd0;
      bit_index_next  = 4'd0;
      byte_index_next = 4'd0;
      shift_byte_next = 8'd0;
    end else begin
      case (phase)
        PH_START_LOW: begin
          tick_count_next = timer_hit ? 16'd0 : tick_inc;
          if (timer_hit) phase_next = PH_START_HIGH;
        end
        PH_START_HIGH: begin
          tick_count_next = timer_hit ? 16'd0 : tick_inc;
          if (timer_hit) phase_next = PH_RESP_WAIT;
        end
        PH_RESP_WAIT: begin
          tick_count_next = timer_hit ? 16'd0 : tick_inc;
          if (timer_hit) begin
            if (!in_pin) begin
              phase_next = PH_RESP_GAP;
            end else begin
              ev_fail    = 1'b1;
              phase_next = PH_IDLE;
            end
          end
        end
        PH_RESP_GAP: begin
          tick_count_next = timer_hit ? 16'd0 : tick_inc;
          if (timer_hit) begin
            if (in_pin) begin
              ev_ok      = 1'b1;
              phase_next = PH_RESP_FALL;
            end else begin
              ev_fail    = 1'b1;
              phase_next = PH_IDLE;
            end
          end
        end
        PH_RESP_FALL: begin
          if (!in_pin) phase_next = PH_BIT_HIGH;
        end
        PH_BIT_HIGH: begin
          if (in_pin) begin
            tick_count_next = 16'd0;
            phase_next      = PH_BIT_DELAY;
          end
        end
        PH_BIT_DELAY: begin
          tick_count_next = timer_hit ? 16'd0 : tick_inc;
          if (timer_hit) begin
            fin_byte        = {shift_byte[6:0], in_pin};
            fin_bits        = bit_index + 4'd1;
            shift_byte_next = fin_byte;
            bit_index_next  = fin_bits;
            // a zero bit already has the line low
            if (!in_pin) do_finish = 1'b1;
            else phase_next = PH_BIT_FALL;
          end
        end
        PH_BIT_FALL: begin
          if (!in_pin) do_finish = 1'b1;
        end
        default: phase_next = PH_IDLE;
      endcase

      if (do_finish) begin
        if (fin_bits < BITS_PER_BYTE) begin
          phase_next = PH_BIT_HIGH;
        end else begin
          ev_byte = 1'b1;
          ev_data = fin_byte;
          // count of zero behaves as one byte
          if (byte_count_inc >= {1'b0, bytes_to_read}) begin
            ev_last    = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_BIT_HIGH;
          end
          byte_index_next = byte_count_inc[3:0];
          bit_index_next  = 4'd0;
          shift_byte_next = 8'd0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // result fields, taken from the phase after this step
  // ---------------------------------------------------------------------
  always_comb begin
    case (phase_next)
      PH_START_LOW:  drive_d = DRIVE_LOW;
      PH_START_HIGH: drive_d = DRIVE_HIGH;
      default:       drive_d = DRIVE_RELEASE;
    endcase
    busy_d   = (phase_next != PH_IDLE);
    status_d = ev_ok ? RESP_OK : (ev_fail ? RESP_FAIL : RESP_NONE);
    bvalid_d = ev_byte;
    data_d   = ev_data;
    last_d   = ev_last;
  end

  // ---------------------------------------------------------------------
  // state and result registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= 16'd0;
      bit_index  <= 4'd0;
      byte_index <= 4'd0;
      shift_byte <= 8'd0;
    end else if (step) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      byte_index <= byte_index_next;
      shift_byte <= shift_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (step) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result.line_drive      <= drive_d;
      result.busy_res        <= busy_d;
      result.response_status <= status_d;
      result.byte_valid      <= bvalid_d;
      result.data_byte       <= data_d;
      result.last_byte       <= last_d;
    end
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  // bit counter never runs past a full byte
  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= BITS_PER_BYTE)
    else $error("bit index out of range");

  // the last byte ends the transaction
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.last_byte |-> result.byte_valid && !result.busy_res)
    else $error("last byte while still busy");

  // a failed response drops back to idle with the line released
  a_fail_idle: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.response_status == RESP_FAIL |->
      !result.busy_res && result.line_drive == DRIVE_RELEASE)
    else $error("failed response left the sequencer busy");

  // a step always loads the result register
  a_step_loads: assert property (@(posedge clk) disable iff (rst)
    step |=> result.valid)
    else $error("result lost after a step");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

// bench for the single-wire sensor reader: every accepted request is run
// through a cycle-free model of the sequencer and the result it should give
// is queued; each result the block hands out is matched field by field
// against the oldest queued one
module tb_top;
  import swsr_pkg::*;

  // one result per request, packed in port order
  typedef struct packed {
    logic [1:0] drive;
    logic       busy;
    logic [1:0] status;
    logic       byte_ok;
    logic [7:0] data;
    logic       last;
  } reading_t;

  // one row of the directed table; the typed reading only counts when typed is set
  typedef struct packed {
    logic     func;
    logic     pin;
    logic     typed;
    reading_t want;
  } request_row_t;

  localparam int unsigned CYCLE_LIMIT   = 200_000;
  // two-stage pipe through the block, plus margin
  localparam int unsigned SETTLE_CYCLES = 4;

  // unused register slots past the last real register
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  localparam logic [15:0] DEFAULT_START_LOW  = 16'd500;
  localparam logic [7:0]  DEFAULT_START_HIGH = 8'd30;
  localparam logic [7:0]  DEFAULT_RESP_WAIT  = 8'd40;
  localparam logic [7:0]  DEFAULT_RESP_GAP   = 8'd80;
  localparam logic [7:0]  DEFAULT_BIT_SAMPLE = 8'd40;
  localparam logic [3:0]  DEFAULT_BYTES      = 4'd5;

  // readings that can be told without running the sequencer model
  localparam reading_t QUIET      = '{DRIVE_RELEASE, 1'b0, RESP_NONE, 1'b0, 8'h00, 1'b0};
  localparam reading_t PULSE_LOW  = '{DRIVE_LOW, 1'b1, RESP_NONE, 1'b0, 8'h00, 1'b0};
  localparam reading_t PULSE_HIGH = '{DRIVE_HIGH, 1'b1, RESP_NONE, 1'b0, 8'h00, 1'b0};
  localparam reading_t REPLY_FAIL = '{DRIVE_RELEASE, 1'b0, RESP_FAIL, 1'b0, 8'h00, 1'b0};
  localparam reading_t REPLY_OK   = '{DRIVE_RELEASE, 1'b1, RESP_OK, 1'b0, 8'h00, 1'b0};

  // directed part, run with every delay register at zero (acts as one tick)
  // and the byte count at zero (acts as one byte)
  localparam request_row_t DIRECTED_ROWS [25] = '{
    '{FUNC_TICK,  1'b0, 1'b1, QUIET},       // tick while idle, line low
    '{FUNC_START, 1'b1, 1'b1, PULSE_LOW},   // start, pin level ignored
    '{FUNC_TICK,  1'b0, 1'b1, PULSE_HIGH},  // low pulse over after one tick
    '{FUNC_START, 1'b0, 1'b1, PULSE_LOW},   // start while busy restarts
    '{FUNC_TICK,  1'b1, 1'b0, QUIET},
    '{FUNC_TICK,  1'b0, 1'b0, QUIET},
    '{FUNC_TICK,  1'b1, 1'b1, REPLY_FAIL},  // line high at the low check
    '{FUNC_TICK,  1'b1, 1'b1, QUIET},       // tick while idle, line high
    '{FUNC_START, 1'b0, 1'b0, QUIET},
    '{FUNC_TICK,  1'b0, 1'b0, QUIET},
    '{FUNC_TICK,  1'b0, 1'b0, QUIET},
    '{FUNC_TICK,  1'b0, 1'b0, QUIET},
    '{FUNC_TICK,  1'b0, 1'b1, REPLY_FAIL},  // line low at the high check
    '{FUNC_START, 1'b1, 1'b0, QUIET},
    '{FUNC_TICK,  1'b1, 1'b0, QUIET},
    '{FUNC_TICK,  1'b1, 1'b0, QUIET},
    '{FUNC_TICK,  1'b0, 1'b0, QUIET},
    '{FUNC_TICK,  1'b1, 1'b1, REPLY_OK},    // good response
    '{FUNC_TICK,  1'b1, 1'b0, QUIET},       // still waiting for the fall
    '{FUNC_TICK,  1'b0, 1'b0, QUIET},
    '{FUNC_TICK,  1'b1, 1'b0, QUIET},       // rising level, sample delay runs
    '{FUNC_TICK,  1'b0, 1'b0, QUIET},       // zero bit, line already low
    '{FUNC_TICK,  1'b1, 1'b0, QUIET},
    '{FUNC_TICK,  1'b1, 1'b0, QUIET},       // one bit, wait for the fall
    '{FUNC_TICK,  1'b0, 1'b0, QUIET}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  swsr_sense_if  sense_ch ();
  swsr_result_if result_ch ();

  single_wire_sensor_reader_top u_top (
    .clk     (clk),
    .rst     (rst),
    .sense   (sense_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // register copies seen by the sequencer model
  logic [15:0] start_low_cfg;
  logic [7:0]  start_high_cfg;
  logic [7:0]  resp_wait_cfg;
  logic [7:0]  resp_gap_cfg;
  logic [7:0]  sample_cfg;
  logic [3:0]  bytes_cfg;

  // sequencer model state
  phase_t      seq_phase;
  logic [15:0] tick_cnt;
  logic [3:0]  bit_idx;
  logic [3:0]  byte_idx;
  logic [7:0]  shift_reg;
  logic        resp_seen;

  reading_t    expected_readings [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // sender pacing and the sensor's plan for the byte being sent
  int unsigned burst_left = 0;
  logic [7:0]  byte_plan  = 8'h00;
  bit          noisy_txn  = 1'b0;

  // phase timer: true on the tick that ends a phase of len ticks
  function automatic bit phase_timer_done(input logic [15:0] len);
    tick_cnt = tick_cnt + 16'd1;
    if (tick_cnt >= len) begin
      tick_cnt = 16'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // line has gone low after a sampled bit: hand out the byte once it is full
  function automatic void close_bit(inout reading_t r);
    if (bit_idx < BITS_PER_BYTE) begin
      seq_phase = PH_BIT_HIGH;
      return;
    end
    r.byte_ok = 1'b1;
    r.data    = shift_reg;
    if ({1'b0, byte_idx} + 5'd1 >= {1'b0, bytes_cfg}) begin
      r.last    = 1'b1;
      seq_phase = PH_IDLE;
    end else begin
      seq_phase = PH_BIT_HIGH;
    end
    byte_idx  = byte_idx + 4'd1;
    bit_idx   = 4'd0;
    shift_reg = 8'h00;
  endfunction

  // one step of the sequencer for one accepted request
  function automatic reading_t predict_reading(input logic f, input logic p);
    reading_t r;
    r = QUIET;
    if (f == FUNC_START) begin
      seq_phase = PH_START_LOW;
      tick_cnt  = 16'd0;
      bit_idx   = 4'd0;
      byte_idx  = 4'd0;
      shift_reg = 8'h00;
      resp_seen = 1'b0;
    end else begin
      case (seq_phase)
        PH_START_LOW: begin
          if (phase_timer_done(start_low_cfg)) seq_phase = PH_START_HIGH;
        end
        PH_START_HIGH: begin
          if (phase_timer_done({8'd0, start_high_cfg})) seq_phase = PH_RESP_WAIT;
        end
        PH_RESP_WAIT: begin
          if (phase_timer_done({8'd0, resp_wait_cfg})) begin
            if (!p) begin
              seq_phase = PH_RESP_GAP;
            end else begin
              r.status  = RESP_FAIL;
              seq_phase = PH_IDLE;
            end
          end
        end
        PH_RESP_GAP: begin
          if (phase_timer_done({8'd0, resp_gap_cfg})) begin
            if (p) begin
              r.status  = RESP_OK;
              resp_seen = 1'b1;
              seq_phase = PH_RESP_FALL;
            end else begin
              r.status  = RESP_FAIL;
              seq_phase = PH_IDLE;
            end
          end
        end
        PH_RESP_FALL: begin
          if (!p) seq_phase = PH_BIT_HIGH;
        end
        PH_BIT_HIGH: begin
          if (p) begin
            tick_cnt  = 16'd0;
            seq_phase = PH_BIT_DELAY;
          end
        end
        PH_BIT_DELAY: begin
          if (phase_timer_done({8'd0, sample_cfg})) begin
            shift_reg = {shift_reg[6:0], p};
            bit_idx   = bit_idx + 4'd1;
            if (!p) close_bit(r);
            else seq_phase = PH_BIT_FALL;
          end
        end
        PH_BIT_FALL: begin
          if (!p) close_bit(r);
        end
        default: begin
          seq_phase = PH_IDLE;
        end
      endcase
    end
    if (seq_phase == PH_START_LOW) r.drive = DRIVE_LOW;
    else if (seq_phase == PH_START_HIGH) r.drive = DRIVE_HIGH;
    r.busy = (seq_phase != PH_IDLE);
    return r;
  endfunction

  // sensor side: picks the next request from where the sequencer stands,
  // mostly a well-behaved sensor, sometimes a noisy line or a restart
  task automatic choose_request(input bit starts_ok, input bit noise_ok,
                                output logic f, output logic p);
    f = FUNC_TICK;
    p = 1'($urandom_range(0, 1));
    if (seq_phase == PH_IDLE) begin
      if (starts_ok && $urandom_range(0, 3) == 0) begin
        f         = FUNC_START;
        noisy_txn = noise_ok && ($urandom_range(0, 9) == 0);
      end
      return;
    end
    if (noise_ok && $urandom_range(0, 299) == 0) begin
      // abandon the transaction in flight
      f         = FUNC_START;
      noisy_txn = ($urandom_range(0, 9) == 0);
      return;
    end
    if (noisy_txn) return;
    case (seq_phase)
      PH_RESP_WAIT: p = ($urandom_range(0, 15) == 0);
      PH_RESP_GAP:  p = ($urandom_range(0, 15) != 0);
      PH_RESP_FALL: p = ($urandom_range(0, 2) != 0);
      PH_BIT_HIGH: begin
        p = ($urandom_range(0, 2) == 0);
        // a new byte begins with this rising level
        if (p && bit_idx == 4'd0) begin
          case ($urandom_range(0, 3))
            0:       byte_plan = 8'h00;
            1:       byte_plan = 8'hFF;
            default: byte_plan = 8'($urandom_range(0, 255));
          endcase
        end
      end
      PH_BIT_DELAY: begin
        // the line only counts on the sampling tick
        if ({1'b0, tick_cnt} + 17'd1 >= {9'd0, sample_cfg})
          p = byte_plan[3'd7 - bit_idx[2:0]];
        else
          p = ($urandom_range(0, 7) != 0);
      end
      default: ;
    endcase
  endtask

  // sender: bursts of requests with random gaps; each accepted request is
  // run through the model and its reading queued
  task automatic send_request(input logic f, input logic p, input logic typed,
                              input reading_t want);
    reading_t    predicted;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        sense_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    sense_ch.valid     <= 1'b1;
    sense_ch.func      <= f;
    sense_ch.pin_level <= p;
    @(posedge clk);
    while (!sense_ch.ready) @(posedge clk);
    predicted = predict_reading(f, p);
    expected_readings.push_back(typed ? want : predicted);
  endtask

  // sender holds off until every queued reading has come back
  task automatic drain_results();
    sense_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  // random traffic until budget requests are starts or reach a busy sequencer, then the
  // transaction in flight is brought to its end and the pipe drained
  task automatic run_traffic(input int unsigned budget, input bit noise_ok);
    int unsigned done_items;
    logic        f;
    logic        p;
    done_items = 0;
    while (done_items < budget) begin
      choose_request(1'b1, noise_ok, f, p);
      if (f == FUNC_START || seq_phase != PH_IDLE) done_items++;
      send_request(f, p, 1'b0, QUIET);
    end
    while (seq_phase != PH_IDLE) begin
      choose_request(1'b0, 1'b0, f, p);
      send_request(f, p, 1'b0, QUIET);
    end
    drain_results();
  endtask

  task automatic read_reg(input logic [2:0] idx, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $display("%0t: register %0d read expected %0h got %0h", $time, idx, want, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write one register, keep the model's copy in step, read it back
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] kept;
    kept = 32'd0;
    case (idx)
      REG_START_LOW: begin
        start_low_cfg = value[15:0];
        kept          = {16'd0, value[15:0]};
      end
      REG_START_HIGH: begin
        start_high_cfg = value[7:0];
        kept           = {24'd0, value[7:0]};
      end
      REG_RESP_WAIT: begin
        resp_wait_cfg = value[7:0];
        kept          = {24'd0, value[7:0]};
      end
      REG_RESP_GAP: begin
        resp_gap_cfg = value[7:0];
        kept         = {24'd0, value[7:0]};
      end
      REG_BIT_SAMPLE: begin
        sample_cfg = value[7:0];
        kept       = {24'd0, value[7:0]};
      end
      REG_BYTES: begin
        bytes_cfg = value[3:0];
        kept      = {28'd0, value[3:0]};
      end
      default: ;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (idx <= REG_BYTES) read_reg(idx, kept);
  endtask

  // all six registers; bits above each register's width carry junk
  task automatic load_settings(input logic [15:0] low_ticks, input logic [7:0] high_ticks,
                               input logic [7:0] wait_ticks, input logic [7:0] gap_ticks,
                               input logic [7:0] sample_ticks, input logic [3:0] byte_count);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(REG_START_LOW,  {junk[31:16], low_ticks});
    write_reg(REG_START_HIGH, {junk[23:0], high_ticks});
    write_reg(REG_RESP_WAIT,  {junk[31:8], wait_ticks});
    write_reg(REG_RESP_GAP,   {junk[27:4], gap_ticks});
    write_reg(REG_BIT_SAMPLE, {junk[29:6], sample_ticks});
    write_reg(REG_BYTES,      {junk[31:4], byte_count});
  endtask

  // receiver: ready pattern picked at random between always ready,
  // coin flip, one cycle in four and mostly ready
  initial begin
    int unsigned rx_mode;
    int unsigned rx_count;
    rx_mode  = 0;
    rx_count = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_count % 64 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0:       result_ch.ready <= 1'b1;
        1:       result_ch.ready <= 1'($urandom_range(0, 1));
        2:       result_ch.ready <= (rx_count % 4 == 0);
        default: result_ch.ready <= ($urandom_range(0, 9) != 0);
      endcase
      rx_count++;
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // result side: every accepted result against the oldest queued reading
  always @(posedge clk) begin : result_check
    reading_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: result with nothing queued, drive %0d status %0d byte %0h",
                 $time, result_ch.line_drive, result_ch.response_status,
                 result_ch.data_byte);
        error_count++;
      end else begin
        want = expected_readings.pop_front();
        check_field("line_drive", {6'd0, want.drive}, {6'd0, result_ch.line_drive});
        check_field("busy_res", {7'd0, want.busy}, {7'd0, result_ch.busy_res});
        check_field("response_status", {6'd0, want.status},
                    {6'd0, result_ch.response_status});
        check_field("byte_valid", {7'd0, want.byte_ok}, {7'd0, result_ch.byte_valid});
        check_field("data_byte", want.data, result_ch.data_byte);
        check_field("last_byte", {7'd0, want.last}, {7'd0, result_ch.last_byte});
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // hang guard
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    // every block input known from time zero
    rst                <= 1'b1;
    sense_ch.valid     <= 1'b0;
    sense_ch.func      <= FUNC_TICK;
    sense_ch.pin_level <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= 5'd0;
    pwdata             <= 32'd0;

    // model at its reset state
    start_low_cfg  = DEFAULT_START_LOW;
    start_high_cfg = DEFAULT_START_HIGH;
    resp_wait_cfg  = DEFAULT_RESP_WAIT;
    resp_gap_cfg   = DEFAULT_RESP_GAP;
    sample_cfg     = DEFAULT_BIT_SAMPLE;
    bytes_cfg      = DEFAULT_BYTES;
    seq_phase      = PH_IDLE;
    tick_cnt       = 16'd0;
    bit_idx        = 4'd0;
    byte_idx       = 4'd0;
    shift_reg      = 8'h00;
    resp_seen      = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults
    read_reg(REG_START_LOW,  {16'd0, DEFAULT_START_LOW});
    read_reg(REG_START_HIGH, {24'd0, DEFAULT_START_HIGH});
    read_reg(REG_RESP_WAIT,  {24'd0, DEFAULT_RESP_WAIT});
    read_reg(REG_RESP_GAP,   {24'd0, DEFAULT_RESP_GAP});
    read_reg(REG_BIT_SAMPLE, {24'd0, DEFAULT_BIT_SAMPLE});
    read_reg(REG_BYTES,      {28'd0, DEFAULT_BYTES});

    // directed table: zero delays act as one tick, zero bytes as one byte,
    // writes past the last register change nothing
    load_settings(16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0);
    write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_B, 32'h0000_0001);
    foreach (DIRECTED_ROWS[i])
      send_request(DIRECTED_ROWS[i].func, DIRECTED_ROWS[i].pin, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].want);
    run_traffic(0, 1'b0);

    // short delays, most bytes in range
    load_settings(16'd3, 8'd2, 8'd2, 8'd3, 8'd2, 4'd8);
    run_traffic(350, 1'b1);

    // lower extremes
    load_settings(16'd1, 8'd1, 8'd1, 8'd1, 8'd1, 4'd1);
    run_traffic(200, 1'b1);

    // random short delays, byte counts past the usual range
    load_settings(16'($urandom_range(0, 24)), 8'($urandom_range(0, 12)),
                  8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
                  8'($urandom_range(0, 12)), 4'($urandom_range(9, 15)));
    run_traffic(250, 1'b1);

    // random short delays, byte counts in range
    load_settings(16'($urandom_range(0, 24)), 8'($urandom_range(0, 12)),
                  8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
                  8'($urandom_range(0, 12)), 4'($urandom_range(1, 8)));
    run_traffic(250, 1'b1);

    // longest start-high and response delays, a single clean transaction
    load_settings(16'd1, 8'hFF, 8'hFF, 8'hFF, 8'd2, 4'd1);
    run_traffic(1, 1'b0);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== single_wire_sensor_reader_top.f =====
design/swsr_pkg.sv
design/swsr_sense_if.sv
design/swsr_result_if.sv
design/single_wire_sensor_reader_top.sv
bench/tb_top.sv
